// File: rtl/neighbor_average_blur_3x3_macros.svh
// Assertion helpers, included by rtl/nab_ctrl.sv.
`ifndef NEIGHBOR_AVERAGE_BLUR_3X3_MACROS_SVH
`define NEIGHBOR_AVERAGE_BLUR_3X3_MACROS_SVH

// Check a property on every clock edge outside reset.
`define NAB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition is followed by another one in the next cycle.
`define NAB_ASSERT_NEXT(label, pre, post, msg) \
  `NAB_ASSERT(label, (pre) |=> (post), msg)

`endif

// File: rtl/nab_pkg.sv
`default_nettype none

package nab_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int CNT_W      = $clog2(MAX_WIDTH + 2);
  localparam int BLUR_SHIFT = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WID_W-1:0] IMG_WIDTH_RST  = WID_W'(1024);
  localparam logic [HGT_W-1:0] IMG_HEIGHT_RST = HGT_W'(1024);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic             is_drain;
    logic             emit;
    logic             interior;
    logic             frame_end;
    logic             use_two;
    logic [COL_W-1:0] addr;
    pix_t             pix;
  } s1_t;

endpackage

`default_nettype wire

// File: rtl/nab_in_if.sv
`default_nettype none

interface nab_in_if;
  logic                     valid;
  logic                     ready;
  logic [nab_pkg::CH_W-1:0] in_red;
  logic [nab_pkg::CH_W-1:0] in_green;
  logic [nab_pkg::CH_W-1:0] in_blue;
  logic                     drain;

  modport source (output valid, in_red, in_green, in_blue, drain, input ready);
  modport sink (input valid, in_red, in_green, in_blue, drain, output ready);
endinterface

`default_nettype wire

// File: rtl/nab_out_if.sv
`default_nettype none

interface nab_out_if;
  logic                     valid;
  logic                     ready;
  logic [nab_pkg::CH_W-1:0] out_red;
  logic [nab_pkg::CH_W-1:0] out_green;
  logic [nab_pkg::CH_W-1:0] out_blue;
  logic                     frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/nab_cfg_if.sv
`default_nettype none

interface nab_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [nab_pkg::CFG_IDX_W-1:0]  index;
  logic [nab_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/neighbor_average_blur_3x3.sv
// 3x3 neighbor-average blur on a raster RGB pixel stream.
// in_ch carries one pixel per item (in_red, in_green, in_blue) or, with
// drain set, a request to release one output still owed at frame end.
// out_ch carries the result pixel and frame_end on the last one of a frame.
// cfg_ch writes img_width (index 0) and img_height (index 1); a write
// restarts the frame position but keeps line buffer and window contents.
// Throughput is one item per cycle while out_ch does not stall, set by the
// two 1024 x 24 bit line buffers, each read and written once a cycle at the
// current column. Output k of a frame comes from input k + W + 1 through
// stage 1 and the output register; the final W + 1 outputs (W for a one-row
// frame) leave one per drain item. Pixels sent during draining are dropped.
// Reset clears position counters and the window, and loads 1024 x 1024;
// the line buffers are not cleared and need no sweep.
// When out_ch stalls, the output register holds its item and stage 1 holds
// the next emitting item; in_ch.ready then drops until out_ch moves.
`default_nettype none

module neighbor_average_blur_3x3 (
  input  logic           clk,
  input  logic           rst_n,
  nab_in_if.sink         in_ch,
  nab_out_if.source      out_ch,
  nab_cfg_if.sink        cfg_ch
);

  nab_pkg::pix_t                in_pix;
  nab_pkg::pix_t                above_q, two_q, blur_pix, out_pix_r, out_pix_nxt;
  nab_pkg::s1_t                 s1;
  logic                         s1_valid, s1_go, rd_en, out_free, lane_shift;
  logic [nab_pkg::COL_W-1:0]    rd_addr;
  logic                         out_valid_r, out_valid_nxt, out_fe_r;

  assign in_pix = '{red: in_ch.in_red, green: in_ch.in_green, blue: in_ch.in_blue};
  assign cfg_ch.ready = 1'b1;
  assign out_free = !out_valid_r || out_ch.ready;

  nab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_drain  (in_ch.drain),
    .in_pix    (in_pix),
    .in_ready  (in_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_free  (out_free),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .s1_go     (s1_go)
  );

  assign lane_shift = s1_go && !s1.is_drain;

  nab_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (lane_shift),
    .wr_addr (s1.addr),
    .wr_pix  (s1.pix),
    .above_q (above_q),
    .two_q   (two_q)
  );

  nab_lane u_lane_red (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift    (lane_shift),
    .new_top  (two_q.red),
    .new_mid  (above_q.red),
    .new_bot  (s1.pix.red),
    .interior (s1.interior),
    .result   (blur_pix.red)
  );

  nab_lane u_lane_green (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift    (lane_shift),
    .new_top  (two_q.green),
    .new_mid  (above_q.green),
    .new_bot  (s1.pix.green),
    .interior (s1.interior),
    .result   (blur_pix.green)
  );

  nab_lane u_lane_blue (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift    (lane_shift),
    .new_top  (two_q.blue),
    .new_mid  (above_q.blue),
    .new_bot  (s1.pix.blue),
    .interior (s1.interior),
    .result   (blur_pix.blue)
  );

  always_comb begin
    if (s1.is_drain) begin
      out_pix_nxt = s1.use_two ? two_q : above_q;
    end else begin
      out_pix_nxt = blur_pix;
    end
    if (s1_go && s1.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.emit && s1_valid) begin
      out_pix_r <= out_pix_nxt;
      out_fe_r  <= s1.frame_end;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_red   = out_pix_r.red;
  assign out_ch.out_green = out_pix_r.green;
  assign out_ch.out_blue  = out_pix_r.blue;
  assign out_ch.frame_end = out_fe_r;

endmodule

`default_nettype wire

// File: rtl/nab_ctrl.sv
`default_nettype none
`include "neighbor_average_blur_3x3_macros.svh"

module nab_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_drain,
  input  nab_pkg::pix_t                  in_pix,
  output logic                           in_ready,
  input  logic                           cfg_valid,
  input  logic [nab_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nab_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           out_free,
  output logic                           rd_en,
  output logic [nab_pkg::COL_W-1:0]      rd_addr,
  output logic                           s1_valid,
  output nab_pkg::s1_t                   s1,
  output logic                           s1_go
);

  localparam int COL_W = nab_pkg::COL_W;
  localparam int ROW_W = nab_pkg::ROW_W;
  localparam int WID_W = nab_pkg::WID_W;
  localparam int HGT_W = nab_pkg::HGT_W;
  localparam int CNT_W = nab_pkg::CNT_W;

  logic [WID_W-1:0] img_w_r, img_w_nxt;
  logic [HGT_W-1:0] img_h_r, img_h_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [CNT_W-1:0] pending_r, pending_nxt;
  logic             s1_valid_r;
  nab_pkg::s1_t     s1_r;
  nab_pkg::s1_t     cmd_nxt;

  logic [WID_W-1:0] wid_eff, w_m1;
  logic [HGT_W-1:0] hgt_eff, h_m1;
  logic in_fire, drain_take, pix_take, pix_emit, out_adv, cfg_hit;
  logic in_last_col, in_last_row, out_last_col, out_last_row;

  always_comb begin
    if (img_w_r == '0) begin
      wid_eff = WID_W'(1);
    end else if (img_w_r > WID_W'(nab_pkg::MAX_WIDTH)) begin
      wid_eff = WID_W'(nab_pkg::MAX_WIDTH);
    end else begin
      wid_eff = img_w_r;
    end
    if (img_h_r == '0) begin
      hgt_eff = HGT_W'(1);
    end else if (img_h_r > HGT_W'(nab_pkg::MAX_HEIGHT)) begin
      hgt_eff = HGT_W'(nab_pkg::MAX_HEIGHT);
    end else begin
      hgt_eff = img_h_r;
    end
  end

  assign w_m1 = wid_eff - WID_W'(1);
  assign h_m1 = hgt_eff - HGT_W'(1);

  assign in_last_col  = WID_W'(in_col_r) == w_m1;
  assign in_last_row  = HGT_W'(in_row_r) == h_m1;
  assign out_last_col = WID_W'(out_col_r) == w_m1;
  assign out_last_row = HGT_W'(out_row_r) == h_m1;

  assign s1_go      = s1_valid_r && (!s1_r.emit || out_free);
  assign in_ready   = !s1_valid_r || s1_go;
  assign in_fire    = in_valid && in_ready;
  assign drain_take = in_fire && in_drain && (pending_r != '0);
  assign pix_take   = in_fire && !in_drain && (pending_r == '0);
  assign pix_emit   = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
  assign out_adv    = drain_take || (pix_take && pix_emit);
  assign cfg_hit    = cfg_valid && ((cfg_index == nab_pkg::CFG_IMG_WIDTH) ||
                                    (cfg_index == nab_pkg::CFG_IMG_HEIGHT));

  assign rd_en   = drain_take || pix_take;
  assign rd_addr = in_drain ? out_col_r : in_col_r;

  always_comb begin
    cmd_nxt.is_drain  = in_drain;
    cmd_nxt.emit      = in_drain || pix_emit;
    cmd_nxt.interior  = (out_row_r != '0) && (HGT_W'(out_row_r) != h_m1) &&
                        (out_col_r != '0) && (WID_W'(out_col_r) != w_m1);
    cmd_nxt.frame_end = in_drain && out_last_row && out_last_col;
    cmd_nxt.use_two   = (HGT_W'(out_row_r) + HGT_W'(2)) == hgt_eff;
    cmd_nxt.addr      = rd_addr;
    cmd_nxt.pix       = in_pix;
  end

  always_comb begin
    img_w_nxt   = img_w_r;
    img_h_nxt   = img_h_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pending_nxt = pending_r;
    if (pix_take) begin
      if (in_last_col) begin
        in_col_nxt = '0;
        if (in_last_row) begin
          in_row_nxt = '0;
          if (hgt_eff == HGT_W'(1)) begin
            pending_nxt = CNT_W'(wid_eff);
          end else begin
            pending_nxt = CNT_W'(wid_eff) + CNT_W'(1);
          end
        end else begin
          in_row_nxt = in_row_r + ROW_W'(1);
        end
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
    end
    if (out_adv) begin
      if (out_last_col) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + ROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
    end
    if (drain_take) begin
      pending_nxt = pending_r - CNT_W'(1);
      if (pending_r == CNT_W'(1)) begin
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end
    if (cfg_hit) begin
      if (cfg_index == nab_pkg::CFG_IMG_WIDTH) begin
        img_w_nxt = cfg_data[WID_W-1:0];
      end else begin
        img_h_nxt = cfg_data[HGT_W-1:0];
      end
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      pending_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r    <= nab_pkg::IMG_WIDTH_RST;
      img_h_r    <= nab_pkg::IMG_HEIGHT_RST;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      pending_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      img_w_r   <= img_w_nxt;
      img_h_r   <= img_h_nxt;
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pending_r <= pending_nxt;
      if (rd_en) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_r <= cmd_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

  `NAB_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_go, s1_valid_r && $stable(s1_r), "stage 1 item changed while stalled")
  `NAB_ASSERT(a_drain_at_origin, pending_r != '0 |-> in_row_r == '0 && in_col_r == '0, "input position not at frame start while draining")
  `NAB_ASSERT(a_last_drain_end, drain_take && pending_r == CNT_W'(1) |-> cmd_nxt.frame_end, "last drained item lacks frame end")

endmodule

`default_nettype wire

// File: rtl/nab_line_buf.sv
`default_nettype none

module nab_line_buf (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [nab_pkg::COL_W-1:0]    rd_addr,
  input  logic                         wr_en,
  input  logic [nab_pkg::COL_W-1:0]    wr_addr,
  input  nab_pkg::pix_t                wr_pix,
  output nab_pkg::pix_t                above_q,
  output nab_pkg::pix_t                two_q
);

  nab_pkg::pix_t above_mem [nab_pkg::MAX_WIDTH];
  nab_pkg::pix_t two_mem [nab_pkg::MAX_WIDTH];
  nab_pkg::pix_t above_q_r;
  nab_pkg::pix_t two_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      above_mem[wr_addr] <= wr_pix;
      two_mem[wr_addr]   <= above_q_r;
    end
  end

  // forward a write that lands on the column being read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        above_q_r <= wr_pix;
        two_q_r   <= above_q_r;
      end else begin
        above_q_r <= above_mem[rd_addr];
        two_q_r   <= two_mem[rd_addr];
      end
    end
  end

  assign above_q = above_q_r;
  assign two_q   = two_q_r;

endmodule

`default_nettype wire

// File: rtl/nab_lane.sv
`default_nettype none

module nab_lane (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift,
  input  logic [nab_pkg::CH_W-1:0] new_top,
  input  logic [nab_pkg::CH_W-1:0] new_mid,
  input  logic [nab_pkg::CH_W-1:0] new_bot,
  input  logic                     interior,
  output logic [nab_pkg::CH_W-1:0] result
);

  localparam int CH_W = nab_pkg::CH_W;
  localparam int SH   = nab_pkg::BLUR_SHIFT;

  logic [CH_W-1:0] c1_r [3];
  logic [CH_W-1:0] c2_r [3];
  logic [CH_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '{default: '0};
      c2_r <= '{default: '0};
    end else if (shift) begin
      c1_r <= c2_r;
      c2_r <= '{new_top, new_mid, new_bot};
    end
  end

  // window at the shift: columns c1, c2 and the new one; centre is c2 middle
  assign sum = (c1_r[0] >> SH) + (c2_r[0] >> SH) + (new_top >> SH) +
               (c1_r[1] >> SH) + (new_mid >> SH) +
               (c1_r[2] >> SH) + (c2_r[2] >> SH) + (new_bot >> SH);

  assign result = interior ? sum : c2_r[1];

endmodule

`default_nettype wire

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nab_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam pix_t WHITE = 24'hFFFFFF;
  localparam pix_t BLACK = 24'h000000;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_DRAIN, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHECK_PREDICTED, CHECK_NONE, CHECK_PIXEL} row_check_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] val;
    pix_t                  px;
    row_check_t            chk;
    pix_t                  exp_px;
    logic                  exp_end;
  } plan_row_t;

  typedef struct packed {
    pix_t pix;
    logic frame_end;
  } blur_out_t;

  plan_row_t directed_plan [25] = '{
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, WHITE,       CHECK_NONE,      BLACK,       1'b0},
    '{ROW_DRAIN, CFG_IMG_WIDTH,  13'd0, BLACK,       CHECK_NONE,      BLACK,       1'b0},
    '{ROW_CFG,   CFG_IMG_WIDTH,  13'd0, BLACK,       CHECK_NONE,      BLACK,       1'b0},
    '{ROW_CFG,   CFG_IMG_HEIGHT, 13'd0, BLACK,       CHECK_NONE,      BLACK,       1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, 24'hFF00AA,  CHECK_NONE,      BLACK,       1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, 24'h123456,  CHECK_NONE,      BLACK,       1'b0},
    '{ROW_DRAIN, CFG_IMG_WIDTH,  13'd0, BLACK,       CHECK_PIXEL,     24'hFF00AA,  1'b1},
    '{ROW_DRAIN, CFG_IMG_WIDTH,  13'd0, BLACK,       CHECK_NONE,      BLACK,       1'b0},
    '{ROW_CFG,   CFG_IMG_WIDTH,  13'd3, BLACK,       CHECK_NONE,      BLACK,       1'b0},
    '{ROW_CFG,   CFG_IMG_HEIGHT, 13'd3, BLACK,       CHECK_NONE,      BLACK,       1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, WHITE,       CHECK_NONE,      BLACK,       1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, 24'h80FF01,  CHECK_NONE,      BLACK,       1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, WHITE,       CHECK_NONE,      BLACK,       1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, WHITE,       CHECK_NONE,      BLACK,       1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, BLACK,       CHECK_PIXEL,     WHITE,       1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, WHITE,       CHECK_PIXEL,     24'h80FF01,  1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, WHITE,       CHECK_PIXEL,     WHITE,       1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, WHITE,       CHECK_PIXEL,     WHITE,       1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, WHITE,       CHECK_PREDICTED, BLACK,       1'b0},
    '{ROW_PIXEL, CFG_IMG_WIDTH,  13'd0, BLACK,       CHECK_NONE,      BLACK,       1'b0},
    '{ROW_DRAIN, CFG_IMG_WIDTH,  13'd0, BLACK,       CHECK_PIXEL,     WHITE,       1'b0},
    '{ROW_DRAIN, CFG_IMG_WIDTH,  13'd0, BLACK,       CHECK_PIXEL,     WHITE,       1'b0},
    '{ROW_DRAIN, CFG_IMG_WIDTH,  13'd0, BLACK,       CHECK_PIXEL,     WHITE,       1'b0},
    '{ROW_DRAIN, CFG_IMG_WIDTH,  13'd0, BLACK,       CHECK_PIXEL,     WHITE,       1'b1},
    '{ROW_DRAIN, CFG_IMG_WIDTH,  13'd0, BLACK,       CHECK_NONE,      BLACK,       1'b0}
  };

  int unsigned extreme_sizes [3][2] = '{'{0, 3}, '{3, 0}, '{1, 1}};

  logic clk = 1'b0;
  logic rst_n;

  nab_in_if  in_if ();
  nab_out_if out_if ();
  nab_cfg_if cfg_if ();

  neighbor_average_blur_3x3 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  pix_t        line_prev  [MAX_WIDTH];
  pix_t        line_prev2 [MAX_WIDTH];
  pix_t        win [3][3];
  int unsigned width_reg;
  int unsigned height_reg;
  int unsigned cur_row;
  int unsigned cur_col;
  int unsigned emit_idx;
  int unsigned owed_count;

  blur_out_t   owed_pixels [$];
  int unsigned mismatches;
  int unsigned stall_pct;
  int unsigned paced_items;
  int unsigned drv_width;
  int unsigned drv_height;
  bit          typed_row;
  bit          typed_emits;
  blur_out_t   typed_out;

  function automatic int unsigned clamp_size(input int unsigned raw, input int unsigned hi);
    if (raw < 1) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  task automatic compute_blurred_output(input logic is_drain, input pix_t px,
                                        output bit emits, output blur_out_t res);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned orow;
    int unsigned ocol;
    int unsigned idx;
    int unsigned col;
    int unsigned sum;
    w = clamp_size(width_reg, MAX_WIDTH);
    h = clamp_size(height_reg, MAX_HEIGHT);
    total = w * h;
    emits = 1'b0;
    res = '0;
    if (is_drain) begin
      if (owed_count == 0) return;
      orow = emit_idx / w;
      ocol = emit_idx % w;
      res.pix = (orow + 2 == h) ? line_prev2[ocol] : line_prev[ocol];
      res.frame_end = (emit_idx + 1 == total);
      emits = 1'b1;
      owed_count--;
      emit_idx++;
      if (owed_count == 0) emit_idx = 0;
      return;
    end
    if (owed_count != 0) return;
    col = cur_col;
    idx = cur_row * w + cur_col;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_prev2[col];
    win[1][2] = line_prev[col];
    win[2][2] = px;
    line_prev2[col] = line_prev[col];
    line_prev[col] = px;
    if (idx >= w + 1) begin
      orow = emit_idx / w;
      ocol = emit_idx % w;
      if (orow != 0 && orow + 1 != h && ocol != 0 && ocol + 1 != w) begin
        for (int ch = 0; ch < 3; ch++) begin
          sum = 0;
          for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
              if (r != 1 || c != 1) sum += win[r][c][ch*CH_W +: CH_W] >> BLUR_SHIFT;
          res.pix[ch*CH_W +: CH_W] = CH_W'(sum);
        end
      end else begin
        res.pix = win[1][1];
      end
      emits = 1'b1;
      emit_idx++;
    end
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= h) begin
        cur_row = 0;
        owed_count = total - emit_idx;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : track_stream
    bit        emits;
    blur_out_t predicted;
    blur_out_t want;
    if (rst_n && cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        CFG_IMG_WIDTH: begin
          width_reg = cfg_if.data[WID_W-1:0];
          cur_row = 0; cur_col = 0; emit_idx = 0; owed_count = 0;
        end
        CFG_IMG_HEIGHT: begin
          height_reg = cfg_if.data[HGT_W-1:0];
          cur_row = 0; cur_col = 0; emit_idx = 0; owed_count = 0;
        end
        default: ;
      endcase
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      compute_blurred_output(in_if.drain, {in_if.in_red, in_if.in_green, in_if.in_blue},
                             emits, predicted);
      if (typed_row) begin
        if (typed_emits) owed_pixels.push_back(typed_out);
      end else if (emits) begin
        owed_pixels.push_back(predicted);
      end
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (owed_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: expected no pixel, got %h frame_end %b", $time,
                 {out_if.out_red, out_if.out_green, out_if.out_blue}, out_if.frame_end);
      end else begin
        want = owed_pixels.pop_front();
        compare_field("out_red", want.pix.red, out_if.out_red);
        compare_field("out_green", want.pix.green, out_if.out_green);
        compare_field("out_blue", want.pix.blue, out_if.out_blue);
        compare_field("frame_end", 8'(want.frame_end), 8'(out_if.frame_end));
      end
    end
  end

  task automatic send_item(input logic is_drain, input pix_t px);
    while ($urandom_range(0, 99) < stall_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.drain    <= is_drain;
    in_if.in_red   <= px.red;
    in_if.in_green <= px.green;
    in_if.in_blue  <= px.blue;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    in_if.valid <= 1'b0;
    while (owed_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (idx == CFG_IMG_WIDTH) drv_width = val;
    else drv_height = val;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic stream_frame(input bit broken);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned cut;
    int unsigned owed;
    w = clamp_size(drv_width, MAX_WIDTH);
    h = clamp_size(drv_height, MAX_HEIGHT);
    total = w * h;
    cut = broken ? $urandom_range(0, total - 1) : total;
    for (int unsigned i = 0; i < cut; i++) begin
      if ($urandom_range(0, 24) == 0) send_item(1'b1, pix_t'($urandom));
      send_item(1'b0, pix_t'($urandom));
      paced_items++;
    end
    if (broken) return;
    owed = (total < w + 1) ? total : w + 1;
    for (int unsigned i = 0; i < owed; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(1'b0, pix_t'($urandom));
      send_item(1'b1, pix_t'($urandom));
      paced_items++;
    end
    if ($urandom_range(0, 3) == 0) send_item(1'b1, pix_t'($urandom));
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    plan_row_t   row;
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned frames;
    bit          broken;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.drain = 1'b0;
    in_if.in_red = '0;
    in_if.in_green = '0;
    in_if.in_blue = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_IMG_WIDTH;
    cfg_if.data = '0;
    stall_pct = 30;
    typed_row = 1'b0;
    typed_emits = 1'b0;
    typed_out = '0;
    mismatches = 0;
    paced_items = 0;
    width_reg = IMG_WIDTH_RST;
    height_reg = IMG_HEIGHT_RST;
    drv_width = IMG_WIDTH_RST;
    drv_height = IMG_HEIGHT_RST;
    cur_row = 0;
    cur_col = 0;
    emit_idx = 0;
    owed_count = 0;
    foreach (line_prev[i]) begin
      line_prev[i] = '0;
      line_prev2[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.reg_idx, row.val);
      end else begin
        typed_row = (row.chk != CHECK_PREDICTED);
        typed_emits = (row.chk == CHECK_PIXEL);
        typed_out = {row.exp_px, row.exp_end};
        send_item(row.kind == ROW_DRAIN, row.px);
      end
    end
    typed_row = 1'b0;

    foreach (extreme_sizes[i]) begin
      write_reg(CFG_IMG_WIDTH, extreme_sizes[i][0]);
      write_reg(CFG_IMG_HEIGHT, extreme_sizes[i][1]);
      stream_frame(1'b0);
    end

    paced_items = 0;
    while (paced_items < RANDOM_ITEMS) begin
      stall_pct = (paced_items >= 300 && paced_items < 450) ? 0 : 30;
      w_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
      h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 5);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_IMG_WIDTH, w_raw);
        write_reg(CFG_IMG_HEIGHT, h_raw);
      end else begin
        write_reg(CFG_IMG_HEIGHT, h_raw);
        write_reg(CFG_IMG_WIDTH, w_raw);
      end
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        broken = ($urandom_range(0, 5) == 0);
        stream_frame(broken);
        if (broken) break;
      end
    end
    stall_pct = 30;

    in_if.valid <= 1'b0;
    while (owed_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
